### hw/rtl/lc3_pkg.sv
// Shared types and constants for the LC-3 execute unit.
`default_nettype none
package lc3_pkg;
  localparam int MEM_WORDS_DEF = 65536;
  localparam logic [15:0] START_PC_RST = 16'h3000;

  localparam logic [1:0] CMD_EXEC = 2'd0;
  localparam logic [1:0] CMD_WR   = 2'd1;
  localparam logic [1:0] CMD_RD   = 2'd2;

  localparam logic [3:0] OP_BR  = 4'h0;
  localparam logic [3:0] OP_ADD = 4'h1;
  localparam logic [3:0] OP_LD  = 4'h2;
  localparam logic [3:0] OP_ST  = 4'h3;
  localparam logic [3:0] OP_JSR = 4'h4;
  localparam logic [3:0] OP_AND = 4'h5;
  localparam logic [3:0] OP_LDR = 4'h6;
  localparam logic [3:0] OP_STR = 4'h7;
  localparam logic [3:0] OP_NOT = 4'h9;
  localparam logic [3:0] OP_LDI = 4'hA;
  localparam logic [3:0] OP_STI = 4'hB;
  localparam logic [3:0] OP_JMP = 4'hC;
  localparam logic [3:0] OP_LEA = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  localparam logic [7:0] TV_GETC = 8'h20;
  localparam logic [7:0] TV_OUT  = 8'h21;
  localparam logic [7:0] TV_IN   = 8'h23;
  localparam logic [7:0] TV_HALT = 8'h25;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] instruction;
    logic [15:0] address;
    logic [15:0] write_data;
    logic [7:0]  in_char;
  } item_t;

  typedef struct packed {
    logic [15:0] pc_value;
    logic [2:0]  cond_flags;
    logic [15:0] dest_value;
    logic [15:0] read_data;
    logic        out_valid;
    logic [7:0]  out_char;
    logic        halted;
    logic        illegal;
  } res_t;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v == 16'h0) return 3'd2;
    else if (v[15]) return 3'd4;
    else return 3'd1;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/lc3_fifo.sv
// Small item queue between front and back, and result queue.
`default_nettype none
module lc3_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic do_push, do_pop;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_pop) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
    if (do_push) mem_r[wp_r] <= din;
  end
endmodule
`default_nettype wire

### hw/rtl/lc3_exec.sv
// Back end: architectural state, memory and instruction sequencer.
`default_nettype none
module lc3_exec #(
  parameter int MEM_WORDS = lc3_pkg::MEM_WORDS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          q_empty,
  input  wire lc3_pkg::item_t q_item,
  output logic               q_pop,
  input  wire logic          r_full,
  output logic               r_push,
  output lc3_pkg::res_t      r_res
);
  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [1:0] {S_IDLE, S_M1, S_M2, S_DONE} st_t;

  logic [15:0] mem_r [MEM_WORDS];
  logic [15:0] rf_r [8];
  logic [15:0] pc_r;
  logic [2:0] cc_r;
  logic halt_r;
  st_t st_r;
  lc3_pkg::item_t it_r;
  logic [15:0] rdat_r;

  logic [3:0] op;
  logic [2:0] r1, r2;
  logic [15:0] off9, off6, off11, opnd, pc1, ea;
  logic [15:0] memq;
  logic rd_en, wr_en;
  logic [AW-1:0] rd_a, wr_a;
  logic [15:0] wr_d;

  assign op = it_r.instruction[15:12];
  assign r1 = it_r.instruction[11:9];
  assign r2 = it_r.instruction[8:6];
  assign off9 = {{7{it_r.instruction[8]}}, it_r.instruction[8:0]};
  assign off6 = {{10{it_r.instruction[5]}}, it_r.instruction[5:0]};
  assign off11 = {{5{it_r.instruction[10]}}, it_r.instruction[10:0]};
  assign opnd = it_r.instruction[5] ? {{11{it_r.instruction[4]}}, it_r.instruction[4:0]}
                                    : rf_r[it_r.instruction[2:0]];
  assign pc1 = pc_r + 16'd1;
  assign ea = (op == lc3_pkg::OP_LDR || op == lc3_pkg::OP_STR) ? rf_r[r2] + off6
                                                               : pc1 + off9;
  assign q_pop = (st_r == S_IDLE) && !q_empty;
  assign memq = rdat_r;

  // memory port: one read, one write per cycle, read registered
  always_comb begin
    rd_en = 1'b0;
    rd_a = ea[AW-1:0];
    wr_en = 1'b0;
    wr_a = ea[AW-1:0];
    wr_d = rf_r[r1];
    if (st_r == S_M1) begin
      if (it_r.command == lc3_pkg::CMD_RD) begin
        rd_en = 1'b1;
        rd_a = it_r.address[AW-1:0];
      end else if (it_r.command == lc3_pkg::CMD_EXEC && !halt_r) begin
        rd_en = 1'b1;
      end
    end else if (st_r == S_M2 && op == lc3_pkg::OP_LDI) begin
      // STI keeps the pointer word in rdat_r for the write address
      rd_en = 1'b1;
      rd_a = memq[AW-1:0];
    end
    if (st_r == S_DONE && !r_full) begin
      if (it_r.command == lc3_pkg::CMD_WR) begin
        wr_en = 1'b1;
        wr_a = it_r.address[AW-1:0];
        wr_d = it_r.write_data;
      end else if (it_r.command == lc3_pkg::CMD_EXEC && !halt_r) begin
        if (op == lc3_pkg::OP_ST || op == lc3_pkg::OP_STR) wr_en = 1'b1;
        if (op == lc3_pkg::OP_STI) begin
          wr_en = 1'b1;
          wr_a = memq[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdat_r <= mem_r[rd_a];
    if (wr_en) mem_r[wr_a] <= wr_d;
  end

  // execute and retire
  lc3_pkg::res_t res;
  logic [15:0] pc_n;
  logic [2:0] cc_n;
  logic halt_n;
  logic we_a, we_b;
  logic [2:0] wa_a;
  logic [15:0] wd_a, wd_b;

  always_comb begin
    res = '0;
    pc_n = pc_r;
    cc_n = cc_r;
    halt_n = halt_r;
    we_a = 1'b0; wa_a = r1; wd_a = '0;
    we_b = 1'b0; wd_b = '0;
    if (it_r.command == lc3_pkg::CMD_RD) res.read_data = memq;
    if (it_r.command == lc3_pkg::CMD_EXEC && !halt_r) begin
      pc_n = pc1;
      case (op)
        lc3_pkg::OP_BR: if ((r1 & cc_r) != 3'd0) pc_n = pc1 + off9;
        lc3_pkg::OP_ADD, lc3_pkg::OP_AND, lc3_pkg::OP_NOT, lc3_pkg::OP_LEA,
        lc3_pkg::OP_LD, lc3_pkg::OP_LDI, lc3_pkg::OP_LDR: begin
          we_a = 1'b1;
          case (op)
            lc3_pkg::OP_ADD: wd_a = rf_r[r2] + opnd;
            lc3_pkg::OP_AND: wd_a = rf_r[r2] & opnd;
            lc3_pkg::OP_NOT: wd_a = ~rf_r[r2];
            lc3_pkg::OP_LEA: wd_a = pc1 + off9;
            default: wd_a = memq;
          endcase
          cc_n = lc3_pkg::cc_of(wd_a);
          res.dest_value = wd_a;
        end
        lc3_pkg::OP_JSR: begin
          pc_n = it_r.instruction[11] ? pc1 + off11 : rf_r[r2];
          we_b = 1'b1; wd_b = pc1;
          res.dest_value = pc1;
        end
        lc3_pkg::OP_JMP: pc_n = rf_r[r2];
        lc3_pkg::OP_ST, lc3_pkg::OP_STR, lc3_pkg::OP_STI: ;
        lc3_pkg::OP_TRAP: begin
          we_b = 1'b1; wd_b = pc1;
          res.dest_value = pc1;
          case (it_r.instruction[7:0])
            lc3_pkg::TV_GETC: begin
              we_a = 1'b1; wa_a = 3'd0; wd_a = {8'h00, it_r.in_char};
              res.dest_value = wd_a;
            end
            lc3_pkg::TV_OUT: begin
              res.out_valid = 1'b1; res.out_char = rf_r[0][7:0];
            end
            lc3_pkg::TV_IN: begin
              we_a = 1'b1; wa_a = 3'd0; wd_a = {8'h00, it_r.in_char};
              res.dest_value = wd_a;
              res.out_valid = 1'b1; res.out_char = it_r.in_char;
            end
            lc3_pkg::TV_HALT: halt_n = 1'b1;
            default: res.illegal = 1'b1;
          endcase
        end
        default: res.illegal = 1'b1;
      endcase
    end
    res.pc_value = pc_n;
    res.cond_flags = cc_n;
    res.halted = halt_n;
  end

  assign r_push = (st_r == S_DONE) && !r_full;
  assign r_res = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pc_r <= lc3_pkg::START_PC_RST;
      cc_r <= '0;
      halt_r <= 1'b0;
      for (int i = 0; i < 8; i++) rf_r[i] <= '0;
    end else begin
      if (cfg_we) pc_r <= cfg_data;
      case (st_r)
        S_IDLE: if (!q_empty) begin
          it_r <= q_item;
          st_r <= S_M1;
        end
        S_M1: st_r <= (it_r.command == lc3_pkg::CMD_EXEC && op == lc3_pkg::OP_LDI ||
                       it_r.command == lc3_pkg::CMD_EXEC && op == lc3_pkg::OP_STI) &&
                      !halt_r ? S_M2 : S_DONE;
        S_M2: st_r <= S_DONE;
        S_DONE: if (!r_full) begin
          st_r <= S_IDLE;
          pc_r <= pc_n;
          cc_r <= cc_n;
          halt_r <= halt_n;
          if (we_b) rf_r[7] <= wd_b;
          if (we_a) rf_r[wa_a] <= wd_a;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) r_push |-> st_r == S_DONE)
    else $error("push outside done");
  assert property (@(posedge clk) disable iff (!rst_n) st_r == S_M2 |=> st_r == S_DONE)
    else $error("indirect step lost");
  assert property (@(posedge clk) disable iff (!rst_n) $past(rst_n) && $past(halt_r) |-> halt_r)
    else $error("halt not sticky");
endmodule
`default_nettype wire

### hw/rtl/lc3_instruction_execute.sv
// Top level: LC-3 execute unit with input queue, sequencer and result queue.
// An accepted item passes the input queue, then sequencer states IDLE (dequeue),
//   M1 (memory read) and DONE (retire); LDI/STI also pass M2 for a second memory step.
// The back-end sequencer takes a new item only after retiring the last one and waits
//   in DONE while the result queue is full; it has a single memory read port.
// Input and result queues hold two items each, so both sides stall independently.
// Reset (rst_n low, synchronous): registers and flags clear, PC = 0x3000, queues empty;
//   memory is not cleared.
`default_nettype none
module lc3_instruction_execute #(
  parameter int MEM_WORDS = lc3_pkg::MEM_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_start_pc,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_command,
  input  wire logic [15:0] in_instruction,
  input  wire logic [15:0] in_address,
  input  wire logic [15:0] in_write_data,
  input  wire logic [7:0]  in_in_char,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      out_pc_value,
  output logic [2:0]       out_cond_flags,
  output logic [15:0]      out_dest_value,
  output logic [15:0]      out_read_data,
  output logic             out_out_valid,
  output logic [7:0]       out_out_char,
  output logic             out_halted,
  output logic             out_illegal
);
  lc3_pkg::item_t in_item, q_item;
  lc3_pkg::res_t r_res, o_res;
  logic q_empty, q_pop, r_full, r_push;

  assign in_item = '{command: in_command, instruction: in_instruction,
                     address: in_address, write_data: in_write_data, in_char: in_in_char};

  // front: item queue
  lc3_fifo #(.W($bits(lc3_pkg::item_t)), .DEPTH(lc3_pkg::QDEPTH)) u_inq (
    .clk, .rst_n, .push, .din(in_item), .full,
    .pop(q_pop), .dout(q_item), .empty(q_empty)
  );

  // back: execution sequencer with state and memory
  lc3_exec #(.MEM_WORDS(MEM_WORDS)) u_exec (
    .clk, .rst_n, .cfg_we, .cfg_data(cfg_start_pc),
    .q_empty, .q_item, .q_pop, .r_full, .r_push, .r_res
  );

  // result queue
  lc3_fifo #(.W($bits(lc3_pkg::res_t)), .DEPTH(lc3_pkg::QDEPTH)) u_outq (
    .clk, .rst_n, .push(r_push), .din(r_res), .full(r_full),
    .pop, .dout(o_res), .empty
  );

  assign out_pc_value = o_res.pc_value;
  assign out_cond_flags = o_res.cond_flags;
  assign out_dest_value = o_res.dest_value;
  assign out_read_data = o_res.read_data;
  assign out_out_valid = o_res.out_valid;
  assign out_out_char = o_res.out_char;
  assign out_halted = o_res.halted;
  assign out_illegal = o_res.illegal;
endmodule
`default_nettype wire
